// ----- sv/hta_pkg.sv -----
// Shared constants and types for the hall tachometer moving-average unit.
`default_nettype none

package hta_pkg;

   // Window depth. The average is the window sum divided by this depth.
   localparam int unsigned WINDOW_SIZE = 8;

   localparam int unsigned SAMPLE_W    = 16;
   localparam int unsigned SUM_W       = SAMPLE_W + $clog2(WINDOW_SIZE);
   localparam int unsigned ZCNT_W      = $clog2(WINDOW_SIZE + 1);
   localparam int unsigned COUNT_W     = 16;
   localparam int unsigned TIMER_W     = 24;
   localparam int unsigned PROD_W      = 32;
   localparam int unsigned DIV_STEP_W  = $clog2(PROD_W);
   localparam int unsigned PULSES_W    = 4;
   localparam int unsigned THRESH_W    = 8;
   localparam int unsigned DELAY_W     = 16;

   localparam int unsigned REQ_DATA_W  = 8;
   localparam int unsigned RSP_DATA_W  = 16;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [COUNT_W-1:0] MS_PER_MINUTE = 16'd60000;
   localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
   localparam logic [TIMER_W-1:0] TIMER_MAX     = '1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_PULSE_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DECAY_START     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DECAY_STEP      = 2'd2;

   // Divider status seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// ----- sv/hta_div.sv -----
// Iterative unit: forms 60000 * count and divides it by elapsed, one bit a cycle.
`default_nettype none

module hta_div (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             start,
   input  wire  [hta_pkg::COUNT_W-1:0]     count,
   input  wire  [hta_pkg::TIMER_W-1:0]     elapsed,
   output hta_pkg::div_status_type         status,
   output logic [hta_pkg::SAMPLE_W-1:0]    quotient
);
   import hta_pkg::*;

   logic [PROD_W-1:0]     quo_ff, quo_in;
   logic [TIMER_W-1:0]    rem_ff, rem_in;
   logic [TIMER_W-1:0]    divisor_ff, divisor_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [PROD_W-1:0]     product;
   logic [TIMER_W:0]      shifted;
   logic [TIMER_W:0]      trial;
   logic                  fits;

   assign product = PROD_W'(count) * PROD_W'(MS_PER_MINUTE);
   assign shifted = {rem_ff, quo_ff[PROD_W-1]};
   assign trial   = shifted - {1'b0, divisor_ff};
   assign fits    = (shifted >= {1'b0, divisor_ff});

   always_comb begin
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      step_in    = step_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         quo_in     = product;
         rem_in     = '0;
         divisor_in = elapsed;
         step_in    = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         // The remainder stays below the divisor, so it fits the timer width.
         rem_in  = fits ? trial[TIMER_W-1:0] : shifted[TIMER_W-1:0];
         quo_in  = {quo_ff[PROD_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == DIV_STEP_W'(PROD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;

   // Quotients beyond the sample width saturate.
   assign quotient = (quo_ff[PROD_W-1:SAMPLE_W] != '0) ? '1 : quo_ff[SAMPLE_W-1:0];

endmodule

`default_nettype wire

// ----- sv/hta_win.sv -----
// Sample window shift line with running sum and registered average.
`default_nettype none

module hta_win (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             push,
   input  wire  [hta_pkg::SAMPLE_W-1:0]    sample,
   output logic [hta_pkg::SAMPLE_W-1:0]    average
);
   import hta_pkg::*;

   logic [SAMPLE_W-1:0] taps_ff [WINDOW_SIZE];
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SUM_W-1:0]    avg_full;
   logic [SAMPLE_W-1:0] avg_ff;

   assign sum_in   = sum_ff - SUM_W'(taps_ff[WINDOW_SIZE-1]) + SUM_W'(sample);
   assign avg_full = sum_in / SUM_W'(WINDOW_SIZE);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_SIZE; i++) begin
            taps_ff[i] <= '0;
         end
         sum_ff <= '0;
         avg_ff <= '0;
      end else if (push) begin
         taps_ff[0] <= sample;
         for (int i = 1; i < WINDOW_SIZE; i++) begin
            taps_ff[i] <= taps_ff[i-1];
         end
         sum_ff <= sum_in;
         avg_ff <= avg_full[SAMPLE_W-1:0];
      end
   end

   assign average = avg_ff;

endmodule

`default_nettype wire

// ----- sv/hall_tachometer_moving_average_unit.sv -----
// Top level: tick sequencer, timers, configuration and result register.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tdata[3:0] pulses
//   rsp      out        rsp_tvalid/rsp_tready  tdata[15:0] average_rpm, tuser[0] from_decay
//   csr      in         csr_we                 csr_index, csr_wdata
//
// A tick that gives no result leaves the sequencer idle. A decay tick goes through the push
// and done states; a measuring tick first waits for the 32 steps of the one-bit-a-cycle divider.
// Reset is synchronous and brings the window, counters, state and configuration registers to their defaults.
// A finished result waits in the output register; the next tick is taken meanwhile,
// and only a further result stalls until that register is free.
`default_nettype none

module hall_tachometer_moving_average_unit (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [hta_pkg::REQ_DATA_W-1:0]    req_tdata,   // [3:0] pulses
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [hta_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [15:0] average_rpm
   output logic [0:0]                        rsp_tuser,   // [0] from_decay
   input  wire                               csr_we,
   input  wire  [hta_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [hta_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import hta_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_DIV_START = 5'b00010,
      ST_DIV_WAIT  = 5'b00100,
      ST_PUSH      = 5'b01000,
      ST_DONE      = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [THRESH_W-1:0] threshold_ff;
   logic [DELAY_W-1:0]  decay_start_ff;
   logic [DELAY_W-1:0]  decay_step_ff;
   logic [COUNT_W-1:0]  pulse_count_ff, pulse_count_in;
   logic [TIMER_W-1:0]  since_meas_ff, since_meas_in;
   logic [TIMER_W-1:0]  since_decay_ff, since_decay_in;
   logic [ZCNT_W-1:0]   zeros_ff, zeros_in;
   logic [COUNT_W-1:0]  count_op_ff, count_op_in;
   logic [TIMER_W-1:0]  elapsed_op_ff, elapsed_op_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                from_decay_ff, from_decay_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;
   logic                rsp_flag_ff, rsp_flag_in;

   logic [COUNT_W:0]    count_sum;
   logic [COUNT_W-1:0]  count_next;
   logic [TIMER_W-1:0]  meas_next;
   logic [TIMER_W-1:0]  decay_next;
   logic                take;
   logic                measure;
   logic                decay;
   logic                div_start;
   logic                win_push;
   logic                out_free;
   div_status_type      div_status;
   logic [SAMPLE_W-1:0] div_quotient;
   logic [SAMPLE_W-1:0] win_average;

   hta_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .count    (count_op_ff),
      .elapsed  (elapsed_op_ff),
      .status   (div_status),
      .quotient (div_quotient)
   );

   hta_win u_win (
      .clock   (clock),
      .reset   (reset),
      .push    (win_push),
      .sample  (sample_ff),
      .average (win_average)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign take       = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign div_start  = (state_ff == ST_DIV_START);
   assign win_push   = (state_ff == ST_PUSH);

   // Tick arithmetic: saturating pulse count and timers.
   assign count_sum  = {1'b0, pulse_count_ff} + (COUNT_W + 1)'(req_tdata[PULSES_W-1:0]);
   assign count_next = count_sum[COUNT_W] ? COUNT_MAX : count_sum[COUNT_W-1:0];
   assign meas_next  = (since_meas_ff == TIMER_MAX) ? TIMER_MAX : since_meas_ff + 1'b1;
   assign decay_next = (since_decay_ff == TIMER_MAX) ? TIMER_MAX : since_decay_ff + 1'b1;
   assign measure    = (count_next >= COUNT_W'(threshold_ff));
   assign decay      = (zeros_ff < ZCNT_W'(WINDOW_SIZE)) &&
                       (meas_next > TIMER_W'(decay_start_ff)) &&
                       (decay_next > TIMER_W'(decay_step_ff));

   always_comb begin
      state_in       = state_ff;
      pulse_count_in = pulse_count_ff;
      since_meas_in  = since_meas_ff;
      since_decay_in = since_decay_ff;
      zeros_in       = zeros_ff;
      count_op_in    = count_op_ff;
      elapsed_op_in  = elapsed_op_ff;
      sample_in      = sample_ff;
      from_decay_in  = from_decay_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_flag_in    = rsp_flag_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               pulse_count_in = count_next;
               since_meas_in  = meas_next;
               since_decay_in = decay_next;
               if (measure) begin
                  count_op_in    = count_next;
                  elapsed_op_in  = (meas_next == '0) ? TIMER_W'(1) : meas_next;
                  from_decay_in  = 1'b0;
                  pulse_count_in = '0;
                  since_meas_in  = '0;
                  since_decay_in = '0;
                  zeros_in       = '0;
                  state_in       = ST_DIV_START;
               end else if (decay) begin
                  since_decay_in = '0;
                  zeros_in       = zeros_ff + 1'b1;
                  sample_in      = '0;
                  from_decay_in  = 1'b1;
                  state_in       = ST_PUSH;
               end
            end
         end
         ST_DIV_START: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_status.done) begin
               sample_in = div_quotient;
               state_in  = ST_PUSH;
            end
         end
         ST_PUSH: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // The average is ready; hand it over once the output register is free.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = win_average;
               rsp_flag_in  = from_decay_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      count_op_ff   <= count_op_in;
      elapsed_op_ff <= elapsed_op_in;
      sample_ff     <= sample_in;
      from_decay_ff <= from_decay_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_flag_ff   <= rsp_flag_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         pulse_count_ff <= '0;
         since_meas_ff  <= '0;
         since_decay_ff <= '0;
         zeros_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         threshold_ff   <= THRESH_W'(4);
         decay_start_ff <= DELAY_W'(2000);
         decay_step_ff  <= DELAY_W'(250);
      end else begin
         state_ff       <= state_in;
         pulse_count_ff <= pulse_count_in;
         since_meas_ff  <= since_meas_in;
         since_decay_ff <= since_decay_in;
         zeros_ff       <= zeros_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               REG_PULSE_THRESHOLD: threshold_ff   <= csr_wdata[THRESH_W-1:0];
               REG_DECAY_START:     decay_start_ff <= csr_wdata[DELAY_W-1:0];
               REG_DECAY_STEP:      decay_step_ff  <= csr_wdata[DELAY_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_flag_ff;

endmodule

`default_nettype wire

// ----- sv/hta_checker.sv -----
// Port-level checks for the tachometer unit, bound to the top level.
`default_nettype none

module hta_checker (
   input wire                               clock,
   input wire                               reset,
   input wire                               req_tready,
   input wire                               rsp_tvalid,
   input wire                               rsp_tready,
   input wire  [hta_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input wire  [0:0]                        rsp_tuser
);
   import hta_pkg::*;

   logic [RSP_DATA_W-1:0] last_avg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_avg_ff <= '0;
      end else if (rsp_tvalid && rsp_tready) begin
         last_avg_ff <= rsp_tdata;
      end
   end

   // A stalled result holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Reset leaves the unit ready with no pending result.
   assert property (@(posedge clock) reset |=> !rsp_tvalid && req_tready)
      else $error("unit not idle after reset");

   // A new result is only loaded while the input side is busy with its tick.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without a busy tick");

   // Pushing a zero can never raise the average above the last transferred one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata <= last_avg_ff)
      else $error("decay result above previous average");

endmodule

bind hall_tachometer_moving_average_unit hta_checker u_hta_checker (.*);

`default_nettype wire
